>>> rtl/pts_pkg.sv
// Shared types and constants for the periodic tick scheduler.
// Used by pts_step and periodic_tick_scheduler_core; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pts_pkg;

   localparam int NOW_PORT_W   = 64;
   localparam int DELTA_PORT_W = 32;
   localparam int CSR_DATA_W   = 32;
   localparam int CSR_INDEX_W  = 2;

   typedef enum logic [1:0] {
      MODE_ADVANCE = 2'd0,
      MODE_BEGIN   = 2'd1,
      MODE_END     = 2'd2,
      MODE_SET_EN  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_LIFECYCLE = 2'd1,
      ST_NONMONO   = 2'd2,
      ST_NEVER     = 2'd3
   } status_type;

   localparam logic [CSR_INDEX_W-1:0] CSR_INTERVAL      = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CAN_EVER_TICK = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_ENABLED = 2'd2;

   typedef struct packed {
      logic playing;
      logic pending;
      logic enabled;
   } flags_type;

   typedef struct packed {
      status_type              status;
      logic                    ticked;
      logic [NOW_PORT_W-1:0]   tick_time;
      logic [DELTA_PORT_W-1:0] delta;
   } result_type;

endpackage

`default_nettype wire

>>> rtl/pts_step.sv
// Next-state and result logic for one request of the tick scheduler.
// Depends on pts_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pts_step #(
   parameter int TIME_WIDTH     = 64,
   parameter int DURATION_WIDTH = 32,
   parameter int INTERVAL_WIDTH = 32
) (
   input  wire logic [1:0]                mode,
   input  wire logic [TIME_WIDTH-1:0]     now,
   input  wire logic                      enable_value,
   input  wire logic                      can_ever_tick,
   input  wire logic [INTERVAL_WIDTH-1:0] interval,
   input  wire logic [TIME_WIDTH-1:0]     last_time,
   input  wire logic [TIME_WIDTH-1:0]     prev_time,
   input  wire logic [TIME_WIDTH-1:0]     due_time,
   input  wire pts_pkg::flags_type        flags,
   output logic [TIME_WIDTH-1:0]          last_time_in,
   output logic [TIME_WIDTH-1:0]          prev_time_in,
   output logic [TIME_WIDTH-1:0]          due_time_in,
   output pts_pkg::flags_type             flags_in,
   output pts_pkg::result_type            result
);

   localparam logic [TIME_WIDTH-1:0] TIME_MAX = '1;
   localparam logic [63:0] DUR_MAX64 = {64{1'b1}} >> (64 - DURATION_WIDTH);

   logic [64:0]           sum_w;
   logic [TIME_WIDTH-1:0] deadline;
   logic [TIME_WIDTH-1:0] diff;
   logic [63:0]           diff_ext;
   logic [31:0]           delta_sat;

   assign sum_w    = 65'(now) + 65'(interval);
   assign deadline = (sum_w > 65'(TIME_MAX)) ? TIME_MAX : sum_w[TIME_WIDTH-1:0];
   assign diff     = now - prev_time;
   assign diff_ext = 64'(diff);
   assign delta_sat = (diff_ext > DUR_MAX64) ? DUR_MAX64[31:0] : diff_ext[31:0];

   always_comb begin
      last_time_in     = last_time;
      prev_time_in     = prev_time;
      due_time_in      = due_time;
      flags_in         = flags;
      result.status    = pts_pkg::ST_OK;
      result.ticked    = 1'b0;
      result.tick_time = '0;
      result.delta     = '0;
      case (pts_pkg::mode_type'(mode))
         pts_pkg::MODE_BEGIN: begin
            last_time_in     = now;
            prev_time_in     = now;
            due_time_in      = now;
            flags_in.playing = 1'b1;
            flags_in.pending = 1'b1;
         end
         pts_pkg::MODE_END: begin
            flags_in.playing = 1'b0;
         end
         pts_pkg::MODE_SET_EN: begin
            if (enable_value && !can_ever_tick) begin
               result.status = pts_pkg::ST_NEVER;
            end else if (flags.enabled != enable_value) begin
               flags_in.enabled = enable_value;
               flags_in.pending = 1'b1;
            end
         end
         pts_pkg::MODE_ADVANCE: begin
            if (!flags.playing) begin
               result.status = pts_pkg::ST_LIFECYCLE;
            end else if (now < last_time) begin
               result.status = pts_pkg::ST_NONMONO;
            end else begin
               last_time_in = now;
               if (flags.enabled) begin
                  if (flags.pending) begin
                     flags_in.pending = 1'b0;
                     prev_time_in     = now;
                     due_time_in      = deadline;
                     result.ticked    = 1'b1;
                     result.tick_time = 64'(now);
                  end else if (!((interval != '0) &&
                                 ((now < due_time) || (now == prev_time)))) begin
                     prev_time_in     = now;
                     due_time_in      = deadline;
                     result.ticked    = 1'b1;
                     result.tick_time = 64'(now);
                     result.delta     = delta_sat;
                  end
               end
            end
         end
         default: begin
            result.status = pts_pkg::ST_OK;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> rtl/periodic_tick_scheduler_core.sv
// Top level of the periodic tick scheduler: request register, scheduler state,
// configuration registers and result register. Depends on pts_pkg and pts_step.
`timescale 1ns / 1ps
`default_nettype none

// Accepts one request per clock while req_stall is low and returns exactly one
// response per request, in order. The request is captured in an input register.
// When the output register can load, the scheduler state is read and updated,
// and the response is written to the output register, so consecutive requests
// see each other's effects with no gap. A stalled response holds the output
// register while the input register takes one more request. The user must write
// the configuration port only while no request is in flight; the block itself
// does not enforce this.

module periodic_tick_scheduler_core #(
   parameter int TIME_WIDTH     = 64,
   parameter int DURATION_WIDTH = 32
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic [1:0]                           req_mode,
   input  wire logic [pts_pkg::NOW_PORT_W-1:0]       req_now_ms,
   input  wire logic                                 req_enable_value,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic [1:0]                                rsp_status,
   output logic                                      rsp_ticked,
   output logic [pts_pkg::NOW_PORT_W-1:0]            rsp_tick_time_ms,
   output logic [pts_pkg::DELTA_PORT_W-1:0]          rsp_delta_ms,
   input  wire logic                                 csr_we,
   input  wire logic [pts_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [pts_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   localparam int INTERVAL_WIDTH = (DURATION_WIDTH < 32) ? DURATION_WIDTH : 32;

   logic                      s1_valid_ff;
   logic [1:0]                s1_mode_ff;
   logic [TIME_WIDTH-1:0]     s1_now_ff;
   logic                      s1_en_ff;
   logic                      s2_valid_ff;
   pts_pkg::result_type       s2_result_ff;
   logic                      s2_load;
   logic                      req_accept;

   logic [INTERVAL_WIDTH-1:0] interval_ff;
   logic                      can_ever_ff;
   logic                      start_en_ff;
   logic [TIME_WIDTH-1:0]     last_time_ff;
   logic [TIME_WIDTH-1:0]     prev_time_ff;
   logic [TIME_WIDTH-1:0]     due_time_ff;
   pts_pkg::flags_type        flags_ff;

   logic [TIME_WIDTH-1:0]     last_time_in;
   logic [TIME_WIDTH-1:0]     prev_time_in;
   logic [TIME_WIDTH-1:0]     due_time_in;
   pts_pkg::flags_type        flags_in;
   pts_pkg::result_type       step_result;
   logic                      can_ever_in;
   logic                      start_en_in;

   assign s2_load    = s1_valid_ff && (!s2_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !s2_load;
   assign req_accept = req_valid && !req_stall;

   assign rsp_valid        = s2_valid_ff;
   assign rsp_status       = s2_result_ff.status;
   assign rsp_ticked       = s2_result_ff.ticked;
   assign rsp_tick_time_ms = s2_result_ff.tick_time;
   assign rsp_delta_ms     = s2_result_ff.delta;

   assign can_ever_in = (csr_index == pts_pkg::CSR_CAN_EVER_TICK) ? csr_wdata[0] : can_ever_ff;
   assign start_en_in = (csr_index == pts_pkg::CSR_START_ENABLED) ? csr_wdata[0] : start_en_ff;

   pts_step #(
      .TIME_WIDTH     (TIME_WIDTH),
      .DURATION_WIDTH (DURATION_WIDTH),
      .INTERVAL_WIDTH (INTERVAL_WIDTH)
   ) u_step (
      .mode          (s1_mode_ff),
      .now           (s1_now_ff),
      .enable_value  (s1_en_ff),
      .can_ever_tick (can_ever_ff),
      .interval      (interval_ff),
      .last_time     (last_time_ff),
      .prev_time     (prev_time_ff),
      .due_time      (due_time_ff),
      .flags         (flags_ff),
      .last_time_in  (last_time_in),
      .prev_time_in  (prev_time_in),
      .due_time_in   (due_time_in),
      .flags_in      (flags_in),
      .result        (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s2_load) begin
         s1_valid_ff <= 1'b0;
      end
      if (req_accept) begin
         s1_mode_ff <= req_mode;
         s1_now_ff  <= req_now_ms[TIME_WIDTH-1:0];
         s1_en_ff   <= req_enable_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_load) begin
         s2_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         s2_valid_ff <= 1'b0;
      end
      if (s2_load) begin
         s2_result_ff <= step_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff      <= '0;
         can_ever_ff      <= 1'b1;
         start_en_ff      <= 1'b1;
         last_time_ff     <= '0;
         prev_time_ff     <= '0;
         due_time_ff      <= '0;
         flags_ff.playing <= 1'b0;
         flags_ff.pending <= 1'b0;
         flags_ff.enabled <= 1'b1;
      end else begin
         if (s2_load) begin
            last_time_ff <= last_time_in;
            prev_time_ff <= prev_time_in;
            due_time_ff  <= due_time_in;
            flags_ff     <= flags_in;
         end
         if (csr_we) begin
            case (csr_index)
               pts_pkg::CSR_INTERVAL: begin
                  interval_ff      <= csr_wdata[INTERVAL_WIDTH-1:0];
                  flags_ff.pending <= 1'b1;
               end
               pts_pkg::CSR_CAN_EVER_TICK,
               pts_pkg::CSR_START_ENABLED: begin
                  can_ever_ff      <= can_ever_in;
                  start_en_ff      <= start_en_in;
                  flags_ff.enabled <= can_ever_in && start_en_in;
               end
               default: begin
                  interval_ff <= interval_ff;
               end
            endcase
         end
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      due_time_ff >= prev_time_ff)
      else $error("deadline behind last tick time");

   assert property (@(posedge clock) disable iff (reset)
      (s2_load && step_result.ticked) |-> (flags_ff.playing && flags_ff.enabled))
      else $error("tick while stopped or disabled");

   assert property (@(posedge clock) disable iff (reset)
      (s2_load && step_result.ticked)
      |=> (64'(prev_time_ff) == rsp_tick_time_ms))
      else $error("last tick time does not match response");

   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && s1_valid_ff) |-> s2_load)
      else $error("request register overwritten");

endmodule

`default_nettype wire

>>> bench/periodic_tick_scheduler_core_tb.sv
// Self-checking bench for periodic_tick_scheduler_core: a scoreboard class keeps its
// own copy of the scheduler state and predicts every response in request order.
// Depends on pts_pkg and the core RTL.
`timescale 1ns / 1ps

module periodic_tick_scheduler_core_tb;

   localparam logic [63:0] TIME_TOP = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] DUR_TOP  = 64'h0000_0000_FFFF_FFFF;

   class tick_scoreboard;
      logic [31:0]         interval;
      logic                can_tick;
      logic                start_en;
      logic [63:0]         last_seen;
      logic [63:0]         prev_tick;
      logic [63:0]         next_due;
      logic                playing;
      logic                resched;
      logic                enabled;
      pts_pkg::result_type pending_results[$];
      int                  mismatches;

      function new();
         interval   = '0;
         can_tick   = 1'b1;
         start_en   = 1'b1;
         last_seen  = '0;
         prev_tick  = '0;
         next_due   = '0;
         playing    = 1'b0;
         resched    = 1'b0;
         enabled    = 1'b1;
         mismatches = 0;
      endfunction

      function logic [63:0] deadline_after(logic [63:0] now);
         if (TIME_TOP - now < {32'd0, interval}) return TIME_TOP;
         return now + {32'd0, interval};
      endfunction

      function void write_reg(logic [pts_pkg::CSR_INDEX_W-1:0] idx,
                              logic [pts_pkg::CSR_DATA_W-1:0] data);
         case (idx)
            pts_pkg::CSR_INTERVAL: begin
               interval = data;
               resched  = 1'b1;
            end
            pts_pkg::CSR_CAN_EVER_TICK: begin
               can_tick = data[0];
               enabled  = can_tick & start_en;
            end
            pts_pkg::CSR_START_ENABLED: begin
               start_en = data[0];
               enabled  = can_tick & start_en;
            end
            default: ;
         endcase
      endfunction

      function void note_request(pts_pkg::mode_type mode, logic [63:0] now, logic en_req);
         pts_pkg::result_type r;
         logic [63:0]         gap;
         r = '0;
         r.status = pts_pkg::ST_OK;
         case (mode)
            pts_pkg::MODE_BEGIN: begin
               last_seen = now;
               prev_tick = now;
               next_due  = now;
               playing   = 1'b1;
               resched   = 1'b1;
            end
            pts_pkg::MODE_END: playing = 1'b0;
            pts_pkg::MODE_SET_EN: begin
               if (en_req && !can_tick) begin
                  r.status = pts_pkg::ST_NEVER;
               end else if (enabled != en_req) begin
                  enabled = en_req;
                  resched = 1'b1;
               end
            end
            pts_pkg::MODE_ADVANCE: begin
               if (!playing) begin
                  r.status = pts_pkg::ST_LIFECYCLE;
               end else if (now < last_seen) begin
                  r.status = pts_pkg::ST_NONMONO;
               end else begin
                  last_seen = now;
                  if (enabled && (resched || interval == 0 ||
                                  (now >= next_due && now != prev_tick))) begin
                     gap = resched ? 64'd0 : now - prev_tick;
                     r.ticked    = 1'b1;
                     r.tick_time = now;
                     r.delta     = (gap > DUR_TOP) ? 32'hFFFF_FFFF : gap[31:0];
                     resched     = 1'b0;
                     prev_tick   = now;
                     next_due    = deadline_after(now);
                  end
               end
            end
            default: ;
         endcase
         pending_results.push_back(r);
      endfunction

      function void check_response(pts_pkg::result_type got);
         pts_pkg::result_type want;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response: status %0d ticked %0b time %h delta %h",
                        got.status, got.ticked, got.tick_time, got.delta);
            return;
         end
         want = pending_results.pop_front();
         if (got.status !== want.status || got.ticked !== want.ticked ||
             got.tick_time !== want.tick_time || got.delta !== want.delta) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected %0d/%0b/%h/%h, got %0d/%0b/%h/%h",
                        want.status, want.ticked, want.tick_time, want.delta,
                        got.status, got.ticked, got.tick_time, got.delta);
         end
      endfunction
   endclass

   logic                             clock            = 1'b0;
   logic                             reset            = 1'b1;
   logic                             req_valid        = 1'b0;
   logic                             req_stall;
   logic [1:0]                       req_mode         = pts_pkg::MODE_ADVANCE;
   logic [pts_pkg::NOW_PORT_W-1:0]   req_now_ms       = '0;
   logic                             req_enable_value = 1'b0;
   logic                             rsp_valid;
   logic                             rsp_stall        = 1'b0;
   logic [1:0]                       rsp_status;
   logic                             rsp_ticked;
   logic [pts_pkg::NOW_PORT_W-1:0]   rsp_tick_time_ms;
   logic [pts_pkg::DELTA_PORT_W-1:0] rsp_delta_ms;
   logic                             csr_we           = 1'b0;
   logic [pts_pkg::CSR_INDEX_W-1:0]  csr_index        = pts_pkg::CSR_INTERVAL;
   logic [pts_pkg::CSR_DATA_W-1:0]   csr_wdata        = '0;

   int             send_idle_pct = 20;
   int             stall_pct     = 53;
   tick_scoreboard board;

   periodic_tick_scheduler_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_now_ms       (req_now_ms),
      .req_enable_value (req_enable_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_ticked       (rsp_ticked),
      .rsp_tick_time_ms (rsp_tick_time_ms),
      .rsp_delta_ms     (rsp_delta_ms),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   task automatic send(pts_pkg::mode_type mode, logic [63:0] now, logic en);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid        <= 1'b1;
      req_mode         <= mode;
      req_now_ms       <= now;
      req_enable_value <= en;
      do @(posedge clock); while (req_stall);
      board.note_request(mode, now, en);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (board.pending_results.size() != 0);
   endtask

   task automatic configure(logic [31:0] ival, logic can, logic start_en);
      drain();
      csr_we    <= 1'b1;
      csr_index <= pts_pkg::CSR_INTERVAL;
      csr_wdata <= ival;
      @(posedge clock);
      board.write_reg(pts_pkg::CSR_INTERVAL, ival);
      csr_index <= pts_pkg::CSR_CAN_EVER_TICK;
      csr_wdata <= {31'd0, can};
      @(posedge clock);
      board.write_reg(pts_pkg::CSR_CAN_EVER_TICK, {31'd0, can});
      csr_index <= pts_pkg::CSR_START_ENABLED;
      csr_wdata <= {31'd0, start_en};
      @(posedge clock);
      board.write_reg(pts_pkg::CSR_START_ENABLED, {31'd0, start_en});
      csr_we <= 1'b0;
   endtask

   task automatic directed_run();
      send(pts_pkg::MODE_ADVANCE, 64'd5, 1'b0);
      send(pts_pkg::MODE_SET_EN, 64'd0, 1'b0);
      send(pts_pkg::MODE_SET_EN, 64'd0, 1'b0);
      send(pts_pkg::MODE_SET_EN, 64'd0, 1'b1);
      send(pts_pkg::MODE_BEGIN, 64'd0, 1'b0);
      send(pts_pkg::MODE_ADVANCE, 64'd0, 1'b0);
      send(pts_pkg::MODE_ADVANCE, 64'd0, 1'b1);
      send(pts_pkg::MODE_ADVANCE, 64'd7, 1'b0);
      send(pts_pkg::MODE_ADVANCE, 64'd3, 1'b0);
      send(pts_pkg::MODE_SET_EN, 64'd0, 1'b0);
      send(pts_pkg::MODE_ADVANCE, 64'd9, 1'b0);
      send(pts_pkg::MODE_SET_EN, 64'd0, 1'b1);
      send(pts_pkg::MODE_ADVANCE, 64'd9, 1'b0);
      send(pts_pkg::MODE_END, 64'd0, 1'b0);
      send(pts_pkg::MODE_ADVANCE, 64'd10, 1'b0);
      send(pts_pkg::MODE_BEGIN, TIME_TOP, 1'b0);
      send(pts_pkg::MODE_ADVANCE, TIME_TOP, 1'b0);
      configure(32'hFFFF_FFFF, 1'b1, 1'b1);
      send(pts_pkg::MODE_BEGIN, 64'd0, 1'b0);
      send(pts_pkg::MODE_ADVANCE, 64'd0, 1'b0);
      send(pts_pkg::MODE_ADVANCE, 64'h0000_0000_FFFF_FFFE, 1'b0);
      send(pts_pkg::MODE_ADVANCE, 64'h0000_0001_0000_0005, 1'b0);
      send(pts_pkg::MODE_ADVANCE, TIME_TOP, 1'b0);
      send(pts_pkg::MODE_ADVANCE, TIME_TOP, 1'b0);
      configure(32'd5, 1'b0, 1'b1);
      send(pts_pkg::MODE_SET_EN, 64'd0, 1'b1);
      send(pts_pkg::MODE_SET_EN, 64'd0, 1'b0);
      send(pts_pkg::MODE_ADVANCE, TIME_TOP, 1'b0);
      configure(32'd5, 1'b1, 1'b0);
   endtask

   task automatic random_run(int count);
      logic [63:0] now_t;
      logic [63:0] cur;
      logic        running;
      int          pick;
      int          k;
      cur     = '0;
      running = 1'b0;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (!running || pick < 4) begin
            k = $urandom_range(99);
            if (k < 30) cur = {$urandom, $urandom};
            else if (k < 45) cur = {32'hFFFF_FFFF, $urandom};
            else cur = {32'd0, $urandom_range(0, 1000)};
            running = 1'b1;
            send(pts_pkg::MODE_BEGIN, cur, 1'($urandom_range(1)));
         end else if (pick < 75) begin
            k = $urandom_range(99);
            if (k < 30) now_t = cur + 64'($urandom_range(0, 2));
            else if (k < 60)
               now_t = cur + {$urandom, $urandom} % ({32'd0, board.interval} + 64'd1);
            else if (k < 85)
               now_t = cur + {32'd0, board.interval} + 64'($urandom_range(0, 2));
            else if (k < 95) now_t = cur + {32'd0, $urandom};
            else now_t = cur + {$urandom, $urandom};
            if (now_t >= cur) cur = now_t;
            send(pts_pkg::MODE_ADVANCE, now_t, 1'($urandom_range(1)));
         end else if (pick < 85) begin
            send(pts_pkg::MODE_ADVANCE, cur - 64'($urandom_range(1, 50)),
                 1'($urandom_range(1)));
         end else if (pick < 93) begin
            send(pts_pkg::MODE_SET_EN, {$urandom, $urandom}, 1'($urandom_range(1)));
         end else if (pick < 96) begin
            running = 1'b0;
            send(pts_pkg::MODE_END, {$urandom, $urandom}, 1'($urandom_range(1)));
         end else begin
            send(pts_pkg::mode_type'($urandom_range(3)), {$urandom, $urandom},
                 1'($urandom_range(1)));
         end
         if ($urandom_range(99) < 2) drain();
      end
   endtask

   initial begin
      pts_pkg::result_type got;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            got.status    = pts_pkg::status_type'(rsp_status);
            got.ticked    = rsp_ticked;
            got.tick_time = rsp_tick_time_ms;
            got.delta     = rsp_delta_ms;
            board.check_response(got);
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   initial begin
      logic [31:0] intervals [9];
      logic [1:0]  enables [9];
      board = new();
      intervals = '{32'd0, 32'd1, 32'd3, 32'd10, 32'd1000, 32'hFFFF_FFFF,
                    $urandom_range(2, 50), 32'd7, $urandom_range(0, 200)};
      enables   = '{2'b11, 2'b11, 2'b10, 2'b11, 2'b01, 2'b11, 2'b11, 2'b00, 2'b11};
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      directed_run();
      for (int p = 0; p < 9; p++) begin
         if (p < 3) begin
            send_idle_pct = 20;
            stall_pct     = 53;
         end else if (p < 6) begin
            send_idle_pct = 53;
            stall_pct     = 20;
         end else begin
            send_idle_pct = 0;
            stall_pct     = 0;
         end
         configure(intervals[p], enables[p][1], enables[p][0]);
         random_run(91);
      end
      drain();
      repeat (4) @(posedge clock);
      if (board.mismatches == 0 && board.pending_results.size() == 0)
         $display("periodic_tick_scheduler_core_tb: done, clean");
      else
         $display("periodic_tick_scheduler_core_tb: done, errors");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("periodic_tick_scheduler_core_tb: done, errors");
      $finish;
   end

endmodule
